/* rtl/core/utf8v_pkg.sv */
// Package for the UTF-8 stream validator: status codes, counter width,
// code point limits and the state and result structures.
// No dependencies; every other file of the block imports it.
package utf8v_pkg;

   // Width of the byte and character counters (saturating).
   localparam int COUNT_BITS = 32;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   // Fixed field widths of the result transaction.
   localparam int CP_BITS  = 21;
   localparam int OUT_BITS = 32;

   // Code point limits: lowest legal value per sequence length, and ceiling.
   localparam logic [CP_BITS-1:0] CP_MIN_LEN2 = 21'h00080;
   localparam logic [CP_BITS-1:0] CP_MIN_LEN3 = 21'h00800;
   localparam logic [CP_BITS-1:0] CP_MIN_LEN4 = 21'h10000;
   localparam logic [CP_BITS-1:0] CP_MAX      = 21'h10FFFF;

   // Sequence lengths held in the state.
   localparam logic [2:0] SEQ_LEN_2 = 3'd2;
   localparam logic [2:0] SEQ_LEN_3 = 3'd3;
   localparam logic [2:0] SEQ_LEN_4 = 3'd4;

   typedef enum logic [2:0] {
      ST_PENDING = 3'd0,
      ST_CHAR    = 3'd1,
      ST_ERROR   = 3'd2,
      ST_END_OK  = 3'd3,
      ST_END_BAD = 3'd4
   } status_type;

   // Decoder state carried from one byte to the next.
   typedef struct packed {
      logic [1:0]            bytes_remaining;
      logic [2:0]            sequence_length;
      logic [CP_BITS-1:0]    accumulator;
      logic [COUNT_BITS-1:0] byte_position;
      logic [COUNT_BITS-1:0] character_total;
      logic                  error_seen;
      logic [COUNT_BITS-1:0] error_index;
   } state_type;

   // One result transaction.
   typedef struct packed {
      status_type          status;
      logic [CP_BITS-1:0]  code_point;
      logic [OUT_BITS-1:0] char_count;
      logic [OUT_BITS-1:0] error_position;
   } result_type;

   // Low 32 bits of a counter, zero extended when the counter is narrower.
   function automatic logic [OUT_BITS-1:0] count_to_out(logic [COUNT_BITS-1:0] value);
      logic [63:0] wide;
      wide = 64'(value);
      return wide[OUT_BITS-1:0];
   endfunction

endpackage

/* rtl/core/utf8v_decode.sv */
// Single-step UTF-8 decoder: from the current state and one byte it forms
// the next state and the result. Purely combinational.
// Depends on utf8v_pkg.
module utf8v_decode (
   input  utf8v_pkg::state_type  state_cur,
   input  logic [7:0]            data_byte,
   output utf8v_pkg::state_type  state_next,
   output utf8v_pkg::result_type result
);
   import utf8v_pkg::*;

   logic [CP_BITS-1:0]    acc_shifted;
   logic [1:0]            remaining_dec;
   logic [CP_BITS-1:0]    cp_low;
   logic [COUNT_BITS-1:0] total_inc;

   // Shared helpers for the continuation path and the character count.
   always_comb begin
      acc_shifted   = {state_cur.accumulator[CP_BITS-7:0], data_byte[5:0]};
      remaining_dec = state_cur.bytes_remaining - 2'd1;
      total_inc     = (state_cur.character_total != CNT_MAX) ?
                      state_cur.character_total + 1'b1 : state_cur.character_total;
      unique case (state_cur.sequence_length)
         SEQ_LEN_2: cp_low = CP_MIN_LEN2;
         SEQ_LEN_3: cp_low = CP_MIN_LEN3;
         default:   cp_low = CP_MIN_LEN4;
      endcase
   end

   // Main decision: end of string, ignored byte, lead byte or continuation.
   always_comb begin
      state_next = state_cur;
      if (state_cur.byte_position != CNT_MAX) begin
         state_next.byte_position = state_cur.byte_position + 1'b1;
      end

      result.status         = ST_PENDING;
      result.code_point     = '0;
      result.char_count     = count_to_out(state_cur.character_total);
      result.error_position = '0;

      priority if (data_byte == 8'h00) begin
         // End of string: report and return every register to its reset value.
         state_next = '0;
         if (state_cur.error_seen || state_cur.bytes_remaining != 2'd0) begin
            result.status         = ST_END_BAD;
            result.error_position = state_cur.error_seen ?
                                    count_to_out(state_cur.error_index) :
                                    count_to_out(state_cur.byte_position);
         end else begin
            result.status = ST_END_OK;
         end
      end else if (state_cur.error_seen) begin
         // Bytes after an error are skipped until the terminator.
         result.status = ST_PENDING;
      end else if (state_cur.bytes_remaining == 2'd0) begin
         // A lead byte is expected.
         priority if (data_byte[7] == 1'b0) begin
            state_next.character_total = total_inc;
            result.status     = ST_CHAR;
            result.code_point = CP_BITS'(data_byte);
            result.char_count = count_to_out(total_inc);
         end else if (data_byte[7:6] == 2'b10 || data_byte[7:3] == 5'b11111) begin
            state_next.error_seen      = 1'b1;
            state_next.error_index     = state_cur.byte_position;
            result.status              = ST_ERROR;
            result.error_position      = count_to_out(state_cur.byte_position);
         end else if (data_byte[5] == 1'b0) begin
            state_next.sequence_length = SEQ_LEN_2;
            state_next.bytes_remaining = 2'd1;
            state_next.accumulator     = CP_BITS'(data_byte[4:0]);
         end else if (data_byte[4] == 1'b0) begin
            state_next.sequence_length = SEQ_LEN_3;
            state_next.bytes_remaining = 2'd2;
            state_next.accumulator     = CP_BITS'(data_byte[3:0]);
         end else begin
            state_next.sequence_length = SEQ_LEN_4;
            state_next.bytes_remaining = 2'd3;
            state_next.accumulator     = CP_BITS'(data_byte[2:0]);
         end
      end else if (data_byte[7:6] != 2'b10) begin
         // Bad continuation byte: consumed as the error, not as a new lead.
         state_next.error_seen      = 1'b1;
         state_next.error_index     = state_cur.byte_position;
         state_next.bytes_remaining = 2'd0;
         state_next.sequence_length = 3'd0;
         state_next.accumulator     = '0;
         result.status              = ST_ERROR;
         result.error_position      = count_to_out(state_cur.byte_position);
      end else if (remaining_dec != 2'd0) begin
         // Continuation byte with more to come.
         state_next.accumulator     = acc_shifted;
         state_next.bytes_remaining = remaining_dec;
      end else begin
         // Last byte of a sequence: range check on the finished code point.
         state_next.bytes_remaining = 2'd0;
         state_next.sequence_length = 3'd0;
         state_next.accumulator     = '0;
         if (acc_shifted < cp_low || acc_shifted > CP_MAX) begin
            state_next.error_seen  = 1'b1;
            state_next.error_index = state_cur.byte_position;
            result.status          = ST_ERROR;
            result.error_position  = count_to_out(state_cur.byte_position);
         end else begin
            state_next.character_total = total_inc;
            result.status     = ST_CHAR;
            result.code_point = acc_shifted;
            result.char_count = count_to_out(total_inc);
         end
      end
   end

endmodule

/* rtl/core/utf8_stream_validator_core.sv */
// UTF-8 stream validator top level: input register, decoder state and
// result register around the single-step decoder.
// Depends on utf8v_pkg and utf8v_decode.

// The block takes one byte of a NUL-terminated string per transaction and
// returns exactly one result per byte: status, the code point of a character
// that completes on this byte, the running character count and the index of
// the first error. A byte passes from the input register through the decoder
// into the result register. A byte can be accepted every clock cycle while
// rsp_tready does not hold the flow. The decoder state register closes the
// only loop, one byte long. While a result waits, the input register can
// still take one more byte. After that req_tready stays low until rsp_tready
// is high. When both registers are full, req_tready follows rsp_tready
// combinationally. A zero byte ends the string and returns the block to its
// reset state for the next one.
module utf8_stream_validator_core (
   input  logic        clock,
   input  logic        reset,
   // Byte stream in. tdata: [7:0] data_byte.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // Results out. tdata: [20:0] code_point, [52:21] char_count,
   // [84:53] error_position, [87:85] zero. tuser: [2:0] status.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,
   output logic [2:0]  rsp_tuser
);
   import utf8v_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff,  in_byte_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   state_type  state_ff, state_in;
   result_type step_result;
   logic       step;
   logic       req_take;

   // A byte is decoded when the result register is free or being emptied.
   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_take   = req_tvalid && req_tready;

   utf8v_decode u_decode (
      .state_cur  (state_ff),
      .data_byte  (in_byte_ff),
      .state_next (state_in),
      .result     (step_result)
   );

   // Next values for the input and result registers.
   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);
      in_byte_in   = req_take ? req_tdata : in_byte_ff;
      out_valid_in = step ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_in       = step ? step_result : out_ff;
   end

   // Control and decoder state, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.status;
   assign rsp_tdata  = {3'b000, out_ff.error_position, out_ff.char_count, out_ff.code_point};

   // An end of string leaves the decoder in its reset state.
   assert property (@(posedge clock) disable iff (reset)
      (step && (step_result.status == ST_END_OK || step_result.status == ST_END_BAD))
      |=> (state_ff.byte_position == '0 && !state_ff.error_seen &&
           state_ff.bytes_remaining == 2'd0))
      else $error("decoder state not cleared after end of string");

   // A reported error is remembered until the terminator.
   assert property (@(posedge clock) disable iff (reset)
      (step && step_result.status == ST_ERROR) |=> state_ff.error_seen)
      else $error("error reported but not recorded");

   // An open sequence always has fewer bytes outstanding than its length.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.bytes_remaining != 2'd0) |->
      (3'(state_ff.bytes_remaining) < state_ff.sequence_length && !state_ff.error_seen))
      else $error("inconsistent sequence state");

   // A completed character never lies beyond the code space.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status == ST_CHAR) |-> (out_ff.code_point <= CP_MAX))
      else $error("code point out of range");

endmodule
